[rtl/core/i2cm_pkg.sv]
// shared types, phase codes and constants of the i2c master byte engine
package i2cm_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_S_A    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_S_B    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_P_A    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_P_B    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_P_C    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_W_LO   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_W_HI   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_A_LO   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_A_POLL = 4'd9;
    localparam logic [PHASE_W-1:0] PH_A_END  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_R_LO   = 4'd11;
    localparam logic [PHASE_W-1:0] PH_R_HI   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_K_LO   = 4'd13;
    localparam logic [PHASE_W-1:0] PH_K_HI   = 4'd14;
    localparam logic [PHASE_W-1:0] PH_K_END  = 4'd15;

    localparam logic       OP_TICK = 1'b0;
    localparam logic       OP_CMD  = 1'b1;

    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_STOP      = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ_ACK  = 3'd3;
    localparam logic [2:0] CMD_READ_NACK = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd255;
    localparam logic [7:0]  MASK_MSB        = 8'h80;

    typedef struct packed {
        logic [15:0] half_period;
        logic [7:0]  poll_limit;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  command;
        logic [7:0]  write_data;
        logic        sda_sample;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [15:0]        tick_count;
        logic [7:0]         bit_mask;
        logic [7:0]         shift_byte;
        logic [7:0]         poll_count;
        logic               scl_out;
        logic               sda_out;
        logic               ack_after_read;
        logic [7:0]         read_data;
        logic               no_ack;
    } eng_state_t;

    localparam eng_state_t ENG_STATE_RST = '{
        phase:          PH_IDLE,
        tick_count:     16'd0,
        bit_mask:       8'd0,
        shift_byte:     8'd0,
        poll_count:     8'd0,
        scl_out:        1'b1,
        sda_out:        1'b1,
        ack_after_read: 1'b0,
        read_data:      8'd0,
        no_ack:         1'b0
    };

endpackage

[rtl/core/i2cm_cfg.sv]
// configuration registers: half period and acknowledge poll limit
module i2cm_cfg
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HALF_PERIOD: cfg_next.half_period = cfg_data;
                CFG_POLL_LIMIT:  cfg_next.poll_limit  = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period <= HALF_PERIOD_RST;
            cfg_reg.poll_limit  <= POLL_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/i2cm_step.sv]
// pin sequencer next-state logic for one tick or command item
module i2cm_step
    import i2cm_pkg::*;
(
    input  eng_state_t cur,
    input  item_t      item,
    input  cfg_t       cfg,
    output eng_state_t nxt,
    output logic       done
);

    logic [15:0] hp;
    logic [7:0]  lim;
    logic [15:0] tick_inc;
    logic [7:0]  poll_inc;
    logic [7:0]  mask_shr;
    logic [7:0]  read_acc;

    assign hp       = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
    assign lim      = (cfg.poll_limit == 8'd0) ? 8'd1 : cfg.poll_limit;
    assign tick_inc = cur.tick_count + 16'd1;
    assign poll_inc = cur.poll_count + 8'd1;
    assign mask_shr = cur.bit_mask >> 1;
    assign read_acc = item.sda_sample ? (cur.shift_byte | cur.bit_mask) : cur.shift_byte;

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        if (item.opcode == OP_CMD) begin
            if (cur.phase == PH_IDLE) begin
                case (item.command)
                    CMD_START: begin
                        nxt.tick_count = 16'd0;
                        nxt.sda_out    = 1'b1;
                        nxt.scl_out    = 1'b1;
                        nxt.phase      = PH_S_A;
                    end
                    CMD_STOP: begin
                        nxt.tick_count = 16'd0;
                        nxt.sda_out    = 1'b0;
                        nxt.phase      = PH_P_A;
                    end
                    CMD_WRITE: begin
                        nxt.tick_count = 16'd0;
                        nxt.shift_byte = item.write_data;
                        nxt.bit_mask   = MASK_MSB;
                        nxt.sda_out    = item.write_data[7];
                        nxt.phase      = PH_W_LO;
                    end
                    CMD_READ_ACK, CMD_READ_NACK: begin
                        nxt.tick_count     = 16'd0;
                        nxt.ack_after_read = (item.command == CMD_READ_ACK);
                        nxt.shift_byte     = 8'd0;
                        nxt.bit_mask       = MASK_MSB;
                        nxt.sda_out        = 1'b1;
                        nxt.phase          = PH_R_LO;
                    end
                    default: begin
                        nxt = cur;
                    end
                endcase
            end
        end else if (cur.phase == PH_A_POLL) begin
            if (!item.sda_sample) begin
                nxt.no_ack     = 1'b0;
                nxt.scl_out    = 1'b0;
                nxt.tick_count = 16'd0;
                nxt.phase      = PH_A_END;
            end else begin
                nxt.poll_count = poll_inc;
                if (poll_inc >= lim) begin
                    nxt.no_ack     = 1'b1;
                    nxt.sda_out    = 1'b0;
                    nxt.tick_count = 16'd0;
                    nxt.phase      = PH_P_A;
                end
            end
        end else if (cur.phase != PH_IDLE) begin
            if (tick_inc < hp) begin
                nxt.tick_count = tick_inc;
            end else begin
                nxt.tick_count = 16'd0;
                case (cur.phase)
                    PH_S_A: begin
                        nxt.sda_out = 1'b0;
                        nxt.phase   = PH_S_B;
                    end
                    PH_S_B: begin
                        nxt.scl_out = 1'b0;
                        nxt.phase   = PH_IDLE;
                        done        = 1'b1;
                    end
                    PH_P_A: begin
                        nxt.scl_out = 1'b1;
                        nxt.phase   = PH_P_B;
                    end
                    PH_P_B: begin
                        nxt.sda_out = 1'b1;
                        nxt.phase   = PH_P_C;
                    end
                    PH_P_C: begin
                        nxt.phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_W_LO: begin
                        nxt.scl_out = 1'b1;
                        nxt.phase   = PH_W_HI;
                    end
                    PH_W_HI: begin
                        nxt.scl_out  = 1'b0;
                        nxt.bit_mask = mask_shr;
                        if (mask_shr != 8'd0) begin
                            nxt.sda_out = |(cur.shift_byte & mask_shr);
                            nxt.phase   = PH_W_LO;
                        end else begin
                            nxt.sda_out = 1'b1;
                            nxt.phase   = PH_A_LO;
                        end
                    end
                    PH_A_LO: begin
                        nxt.scl_out    = 1'b1;
                        nxt.poll_count = 8'd0;
                        nxt.phase      = PH_A_POLL;
                    end
                    PH_A_END: begin
                        nxt.phase = PH_IDLE;
                        done      = 1'b1;
                    end
                    PH_R_LO: begin
                        nxt.scl_out = 1'b1;
                        nxt.phase   = PH_R_HI;
                    end
                    PH_R_HI: begin
                        nxt.shift_byte = read_acc;
                        nxt.scl_out    = 1'b0;
                        nxt.bit_mask   = mask_shr;
                        if (mask_shr != 8'd0) begin
                            nxt.phase = PH_R_LO;
                        end else begin
                            nxt.read_data = read_acc;
                            nxt.sda_out   = !cur.ack_after_read;
                            nxt.phase     = PH_K_LO;
                        end
                    end
                    PH_K_LO: begin
                        nxt.scl_out = 1'b1;
                        nxt.phase   = PH_K_HI;
                    end
                    PH_K_HI: begin
                        nxt.scl_out = 1'b0;
                        nxt.phase   = PH_K_END;
                    end
                    PH_K_END: begin
                        nxt.sda_out = 1'b1;
                        nxt.phase   = PH_IDLE;
                        done        = 1'b1;
                    end
                    default: begin
                        nxt.phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

[rtl/core/i2c_master_byte_engine_unit.sv]
// top level of the i2c master byte engine: item pipeline, engine state and result register
// The engine takes one item per clock while s_tready is high: a tick of time (tuser 0) or
// a new command (tuser 1), and returns exactly one result per item, in order. An item taken
// into the input register is stepped through the phase sequencer into the engine state,
// which also serves as the result register, once the result side is free, and the result
// is presented there until it is transferred. The sequencer finishes one item per cycle, so
// the sustained rate is one item per clock when the result side keeps tready high.
// Bus timing is counted in tick items, half_period_ticks per SCL or SDA phase.
// Configuration writes belong to idle periods, when every accepted item has had its result
// taken.
module i2c_master_byte_engine_unit
    import i2cm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    // items in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,  // command[2:0], write_data[10:3], sda_sample[11]
    input  logic                 s_tuser,  // opcode
    // results out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scl_level[0], sda_level[1], ready_res[2], done_res[3], read_data[11:4], no_ack[12]
    output logic [15:0]          m_tdata
);

    cfg_t       cfg;
    item_t      in_item_reg;
    logic       in_valid_reg;
    eng_state_t state_reg;
    eng_state_t state_next;
    logic       done_next;
    logic       out_valid_reg;
    logic       out_done_reg;
    logic       out_free;
    logic       step_fire;

    i2cm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cm_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .done (done_next)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.opcode     <= s_tuser;
            in_item_reg.command    <= s_tdata[2:0];
            in_item_reg.write_data <= s_tdata[10:3];
            in_item_reg.sda_sample <= s_tdata[11];
        end
    end

    // engine state, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_STATE_RST;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_done_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       state_reg.no_ack,
                       state_reg.read_data,
                       out_done_reg,
                       (state_reg.phase == PH_IDLE),
                       state_reg.sda_out,
                       state_reg.scl_out};

    // a completed command always leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && done_next |-> state_next.phase == PH_IDLE)
        else $error("command completed without returning to idle");

    // engine state only moves when an item is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_fire |=> $stable(state_reg))
        else $error("engine state changed without an item");

    // input side only stalls when a held item is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a waiting item");

    // a tick leaves the tick counter below the half period
    a_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_item_reg.opcode == OP_TICK && cfg.half_period > 16'd1
            |-> state_next.tick_count < cfg.half_period)
        else $error("tick counter ran past the half period");

endmodule

[bench/tb_i2c_master_byte_engine_unit.sv]
// testbench for the i2c master byte engine: directed bus sequences, then random traffic
module tb_i2c_master_byte_engine_unit;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE  = 2'd3;
    localparam logic [2:0]           CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0]           CMD_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] pad;
        logic       no_ack;
        logic [7:0] read_data;
        logic       done_res;
        logic       ready_res;
        logic       sda_level;
        logic       scl_level;
    } res_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        item_t                item;
        logic [4:0]           reps;
        logic                 typed;
        res_t                 want;
    } dir_row_t;

    localparam res_t  IDLE_RES = '{3'b000, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam res_t  NO_RES   = '0;
    localparam item_t NO_ITEM  = '{OP_TICK, CMD_START, 8'h00, 1'b0};

    localparam int NUM_ROWS = 22;
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // idle after reset: ticks and unknown commands leave the bus alone
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b0},
          5'd1, 1'b1, IDLE_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_RSVD_FIRST, 8'hFF, 1'b1},
          5'd1, 1'b1, IDLE_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_RSVD_LAST, 8'h5A, 1'b0},
          5'd1, 1'b1, IDLE_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_READ_NACK, 8'hFF, 1'b1},
          5'd1, 1'b1, IDLE_RES},
        // zero half period and zero poll limit behave as one
        '{1'b1, CFG_HALF_PERIOD, 16'h0000, NO_ITEM, 5'd0, 1'b0, NO_RES},
        '{1'b1, CFG_POLL_LIMIT,  16'h0000, NO_ITEM, 5'd0, 1'b0, NO_RES},
        '{1'b1, CFG_IDX_SPARE,   16'hFFFF, NO_ITEM, 5'd0, 1'b0, NO_RES},
        // write straight from scl high, busy command ignored, ack timeout into stop
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_WRITE, 8'hFF, 1'b1},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_START, 8'h00, 1'b0},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b1},
          5'd21, 1'b0, NO_RES},
        '{1'b1, CFG_POLL_LIMIT,  16'h0002, NO_ITEM, 5'd0, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_START, 8'h00, 1'b0},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b0},
          5'd2, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_WRITE, 8'h00, 1'b0},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b0},
          5'd19, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_READ_ACK, 8'h00, 1'b0},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b1},
          5'd19, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_READ_NACK, 8'h00, 1'b0},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b0},
          5'd19, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_WRITE, 8'h5A, 1'b0},
          5'd1, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_TICK, CMD_START, 8'h00, 1'b1},
          5'd22, 1'b0, NO_RES},
        '{1'b0, CFG_HALF_PERIOD, 16'h0000, '{OP_CMD, CMD_STOP, 8'h00, 1'b0},
          5'd1, 1'b0, NO_RES}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;

    eng_state_t bus_state     = ENG_STATE_RST;
    cfg_t       bus_cfg       = '{HALF_PERIOD_RST, POLL_LIMIT_RST};
    res_t       expected_bus[$];
    bit         peer_silent   = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         bad_results   = 0;

    i2c_master_byte_engine_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void begin_command(input logic [2:0] cmd, input logic [7:0] data);
        bus_state.tick_count = 16'd0;
        case (cmd)
            CMD_START: begin
                bus_state.sda_out = 1'b1;
                bus_state.scl_out = 1'b1;
                bus_state.phase   = PH_S_A;
            end
            CMD_STOP: begin
                bus_state.sda_out = 1'b0;
                bus_state.phase   = PH_P_A;
            end
            CMD_WRITE: begin
                bus_state.shift_byte = data;
                bus_state.bit_mask   = MASK_MSB;
                bus_state.sda_out    = data[7];
                bus_state.phase      = PH_W_LO;
            end
            CMD_READ_ACK, CMD_READ_NACK: begin
                bus_state.ack_after_read = (cmd == CMD_READ_ACK);
                bus_state.shift_byte     = 8'h00;
                bus_state.bit_mask       = MASK_MSB;
                bus_state.sda_out        = 1'b1;
                bus_state.phase          = PH_R_LO;
            end
            default: ;
        endcase
    endfunction

    function automatic logic advance_bus(input logic sda_in);
        logic [15:0] hp;
        logic [7:0]  lim;
        hp  = (bus_cfg.half_period == 16'd0) ? 16'd1 : bus_cfg.half_period;
        lim = (bus_cfg.poll_limit == 8'd0) ? 8'd1 : bus_cfg.poll_limit;
        if (bus_state.phase == PH_IDLE) return 1'b0;
        if (bus_state.phase == PH_A_POLL) begin
            if (!sda_in) begin
                bus_state.no_ack     = 1'b0;
                bus_state.scl_out    = 1'b0;
                bus_state.tick_count = 16'd0;
                bus_state.phase      = PH_A_END;
            end else begin
                bus_state.poll_count = bus_state.poll_count + 8'd1;
                if (bus_state.poll_count >= lim) begin
                    bus_state.no_ack     = 1'b1;
                    bus_state.sda_out    = 1'b0;
                    bus_state.tick_count = 16'd0;
                    bus_state.phase      = PH_P_A;
                end
            end
            return 1'b0;
        end
        bus_state.tick_count = bus_state.tick_count + 16'd1;
        if (bus_state.tick_count < hp) return 1'b0;
        bus_state.tick_count = 16'd0;
        case (bus_state.phase)
            PH_S_A: begin
                bus_state.sda_out = 1'b0;
                bus_state.phase   = PH_S_B;
            end
            PH_S_B: begin
                bus_state.scl_out = 1'b0;
                bus_state.phase   = PH_IDLE;
                return 1'b1;
            end
            PH_P_A: begin
                bus_state.scl_out = 1'b1;
                bus_state.phase   = PH_P_B;
            end
            PH_P_B: begin
                bus_state.sda_out = 1'b1;
                bus_state.phase   = PH_P_C;
            end
            PH_P_C: begin
                bus_state.phase = PH_IDLE;
                return 1'b1;
            end
            PH_W_LO: begin
                bus_state.scl_out = 1'b1;
                bus_state.phase   = PH_W_HI;
            end
            PH_W_HI: begin
                bus_state.scl_out  = 1'b0;
                bus_state.bit_mask = bus_state.bit_mask >> 1;
                if (bus_state.bit_mask != 8'h00) begin
                    bus_state.sda_out = |(bus_state.shift_byte & bus_state.bit_mask);
                    bus_state.phase   = PH_W_LO;
                end else begin
                    bus_state.sda_out = 1'b1;
                    bus_state.phase   = PH_A_LO;
                end
            end
            PH_A_LO: begin
                bus_state.scl_out    = 1'b1;
                bus_state.poll_count = 8'd0;
                bus_state.phase      = PH_A_POLL;
            end
            PH_A_END: begin
                bus_state.phase = PH_IDLE;
                return 1'b1;
            end
            PH_R_LO: begin
                bus_state.scl_out = 1'b1;
                bus_state.phase   = PH_R_HI;
            end
            PH_R_HI: begin
                if (sda_in) bus_state.shift_byte = bus_state.shift_byte | bus_state.bit_mask;
                bus_state.scl_out  = 1'b0;
                bus_state.bit_mask = bus_state.bit_mask >> 1;
                if (bus_state.bit_mask != 8'h00) begin
                    bus_state.phase = PH_R_LO;
                end else begin
                    bus_state.read_data = bus_state.shift_byte;
                    bus_state.sda_out   = !bus_state.ack_after_read;
                    bus_state.phase     = PH_K_LO;
                end
            end
            PH_K_LO: begin
                bus_state.scl_out = 1'b1;
                bus_state.phase   = PH_K_HI;
            end
            PH_K_HI: begin
                bus_state.scl_out = 1'b0;
                bus_state.phase   = PH_K_END;
            end
            PH_K_END: begin
                bus_state.sda_out = 1'b1;
                bus_state.phase   = PH_IDLE;
                return 1'b1;
            end
            default: bus_state.phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic res_t predict_bus(input item_t it);
        res_t r;
        logic done;
        r    = '0;
        done = 1'b0;
        if (it.opcode == OP_CMD) begin
            if (bus_state.phase == PH_IDLE) begin_command(it.command, it.write_data);
        end else begin
            done = advance_bus(it.sda_sample);
        end
        r.scl_level = bus_state.scl_out;
        r.sda_level = bus_state.sda_out;
        r.ready_res = (bus_state.phase == PH_IDLE);
        r.done_res  = done;
        r.read_data = bus_state.read_data;
        r.no_ack    = bus_state.no_ack;
        return r;
    endfunction

    // s_tvalid stays high after a transfer; each item sets it again and idle gaps clear it
    task automatic feed_item(input item_t it, input logic typed, input res_t typed_res);
        res_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= {4'b0000, it.sda_sample, it.write_data, it.command};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_bus(it);
        expected_bus.push_back(typed ? typed_res : want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (expected_bus.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD) bus_cfg.half_period = val;
        else if (idx == CFG_POLL_LIMIT) bus_cfg.poll_limit = val[7:0];
    endtask

    task automatic run_traffic(input int n_items);
        int    counted;
        int    pick;
        item_t it;
        counted = 0;
        while (counted < n_items) begin
            it.opcode     = OP_TICK;
            it.command    = 3'($urandom_range(0, 7));
            it.write_data = 8'($urandom);
            it.sda_sample = 1'($urandom);
            if (bus_state.phase == PH_IDLE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // idle tick or reserved command: ignored
                    if ($urandom_range(0, 1) == 0) begin
                        it.opcode  = OP_CMD;
                        it.command = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
                    end
                end else begin
                    it.opcode = OP_CMD;
                    pick      = $urandom_range(0, 99);
                    if (pick < 20) it.command = CMD_START;
                    else if (pick < 40) it.command = CMD_STOP;
                    else if (pick < 70) it.command = CMD_WRITE;
                    else if (pick < 85) it.command = CMD_READ_ACK;
                    else it.command = CMD_READ_NACK;
                    if (it.command == CMD_WRITE) peer_silent = ($urandom_range(0, 3) == 0);
                    counted++;
                end
            end else if ($urandom_range(0, 19) == 0) begin
                it.opcode = OP_CMD;
            end else begin
                if (bus_state.phase == PH_A_POLL)
                    it.sda_sample = peer_silent || ($urandom_range(0, 2) != 0);
                counted++;
            end
            feed_item(it, 1'b0, NO_RES);
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (expected_bus.size() == 0) begin
            bad_results++;
            if (bad_results <= 10) $display("result transfer with nothing expected: %h", got);
            return;
        end
        want = expected_bus.pop_front();
        if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
            got.ready_res !== want.ready_res || got.done_res !== want.done_res ||
            got.read_data !== want.read_data || got.no_ack !== want.no_ack) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("mismatch exp scl %b sda %b ready %b done %b read %h no_ack %b",
                         want.scl_level, want.sda_level, want.ready_res, want.done_res,
                         want.read_data, want.no_ack);
                $display("         got scl %b sda %b ready %b done %b read %h no_ack %b",
                         got.scl_level, got.sda_level, got.ready_res, got.done_res,
                         got.read_data, got.no_ack);
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(res_t'(m_tdata));
    end

    initial begin
        #2_000_000;
        $display("tb_i2c_master_byte_engine_unit NOT OK");
        $finish;
    end

    initial begin : stimulus
        dir_row_t row;
        item_t    it;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 34;
        recv_idle_pct = 79;
        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.is_cfg) begin
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                for (int k = 0; k < row.reps; k++) feed_item(row.item, row.typed, row.want);
            end
        end
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_POLL_LIMIT, 16'd1);
        run_traffic(150);

        send_idle_pct = 79;
        recv_idle_pct = 34;
        write_reg(CFG_HALF_PERIOD, 16'd3);
        write_reg(CFG_POLL_LIMIT, 16'd255);
        run_traffic(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_HALF_PERIOD, 16'd2);
        write_reg(CFG_POLL_LIMIT, 16'hFF03);
        run_traffic(100);

        // longest half period: start and the first ticks of its first phase
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        it = '{OP_CMD, CMD_START, 8'h00, 1'b0};
        feed_item(it, 1'b0, NO_RES);
        repeat (10) begin
            it = '{OP_TICK, CMD_START, 8'h00, 1'($urandom)};
            feed_item(it, 1'b0, NO_RES);
        end
        s_tvalid <= 1'b0;

        while (expected_bus.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (bad_results == 0 && expected_bus.size() == 0) begin
            $display("tb_i2c_master_byte_engine_unit OK");
        end else begin
            $display("tb_i2c_master_byte_engine_unit NOT OK");
        end
        $finish;
    end

endmodule
